### src/fat12_cte_pkg.sv
// fat12_cte_pkg: shared types and constants of the fat12 cluster table engine
// action and status codes, register indexes, controller states, result record
// no dependencies
package fat12_cte_pkg;

    localparam int ENTRY_W = 12;

    // action codes
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_FIND  = 3'd2;
    localparam logic [2:0] ACT_COUNT = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [0:0] REG_ENTRY_COUNT   = 1'd0;
    localparam logic [0:0] REG_CLUSTER_BYTES = 1'd1;

    localparam logic [12:0] ENTRY_COUNT_RST   = 13'd4096;
    localparam logic [19:0] CLUSTER_BYTES_RST = 20'd512;

    localparam logic [ENTRY_W-1:0] MEDIA_MARK = 12'hFF8;
    localparam logic [ENTRY_W-1:0] CHAIN_END  = 12'hFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_MUL,
        ST_CLEAR,
        ST_HOLD
    } state_t;

    // packed so that status lands in the lowest bits
    typedef struct packed {
        logic [31:0]        free_bytes;
        logic [12:0]        free_count;
        logic [ENTRY_W-1:0] entry_data;
        logic [1:0]         status;
    } result_t;

endpackage

### src/fat12_cte_table.sv
// fat12_cte_table: cluster table storage, one write port and one read port
// read data is registered
// depends on fat12_cte_pkg
module fat12_cte_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [AW-1:0]                     wa,
    input  logic [fat12_cte_pkg::ENTRY_W-1:0] wd,
    input  logic [AW-1:0]                     ra,
    output logic [fat12_cte_pkg::ENTRY_W-1:0] rdata
);

    logic [fat12_cte_pkg::ENTRY_W-1:0] mem_array [DEPTH];
    logic [fat12_cte_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[wa] <= wd;
        end
        rdata_reg <= mem_array[ra];
    end

    assign rdata = rdata_reg;

endmodule

### src/fat12_cluster_table_engine_core.sv
// fat12_cluster_table_engine_core: top level of the fat12 cluster table engine
// controller, configuration registers and output register around the table memory
// depends on fat12_cte_pkg and fat12_cte_table
//
// One item is handled at a time and gives one result. Read, write and unknown
// actions give their result from the execute state that follows the transfer.
// The table sits in a single synchronous memory that delivers one entry per
// cycle, so the scans are set by the scan limit L = min(entry_count, MAX_ENTRIES):
// find free stops at the first zero entry or after L entries, count free visits
// all L entries and then forms the byte product, and clear sweeps every one of
// the MAX_ENTRIES entries. The input is taken again as soon as the previous
// result sits in the output register; a stalled output only delays the item
// behind it. Entries that were never written since reset read back as garbage,
// so clear the table first.
module fat12_cluster_table_engine_core #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // action[2:0], index[14:3], value[26:15]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // status[1:0], entry_data[13:2],
                                       // free_count[26:14], free_bytes[58:27]
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = fat12_cte_pkg::ENTRY_W;
    localparam logic [12:0]   MAX13    = 13'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);

    fat12_cte_pkg::state_t  state_reg, state_next;
    fat12_cte_pkg::result_t m_data_reg, m_data_next;
    fat12_cte_pkg::result_t hold_reg, hold_next;
    fat12_cte_pkg::result_t fin;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    act_reg, act_next;
    logic [11:0]   idx_reg, idx_next;
    logic [EW-1:0] val_reg, val_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [12:0]   entry_count_reg;
    logic [19:0]   cluster_bytes_reg;

    logic          fin_valid;
    logic          out_free;
    logic          idx_ok;
    logic          issue;
    logic [CW-1:0] scan_lim;
    logic [32:0]   prod;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;
    logic [EW-1:0] mem_rdata;

    logic [2:0]    s_action;
    logic [11:0]   s_index;
    logic [EW-1:0] s_value;

    assign s_action = s_axis_tdata[2:0];
    assign s_index  = s_axis_tdata[14:3];
    assign s_value  = s_axis_tdata[26:15];

    assign s_axis_tready = (state_reg == fat12_cte_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_data_reg};

    assign out_free = !m_valid_reg || m_axis_tready;
    assign idx_ok   = ({1'b0, idx_reg} < entry_count_reg) && ({1'b0, idx_reg} < MAX13);
    assign scan_lim = (entry_count_reg < MAX13) ? entry_count_reg[CW-1:0] : CW'(MAX_ENTRIES);
    assign issue    = scan_addr_reg < scan_lim;
    assign prod     = 33'(cnt_reg) * 33'(cluster_bytes_reg);

    fat12_cte_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .wa    (mem_wa),
        .wd    (mem_wd),
        .ra    (mem_ra),
        .rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg   <= fat12_cte_pkg::ENTRY_COUNT_RST;
            cluster_bytes_reg <= fat12_cte_pkg::CLUSTER_BYTES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fat12_cte_pkg::REG_ENTRY_COUNT:   entry_count_reg   <= cfg_wdata[12:0];
                fat12_cte_pkg::REG_CLUSTER_BYTES: cluster_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fat12_cte_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        hold_reg      <= hold_next;
        act_reg       <= act_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        scan_addr_reg <= scan_addr_next;
        pend_idx_reg  <= pend_idx_next;
        cnt_reg       <= cnt_next;
        clr_addr_reg  <= clr_addr_next;
    end

    always_comb begin
        state_next     = state_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        hold_next      = hold_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        cnt_next       = cnt_reg;
        clr_addr_next  = clr_addr_reg;
        mem_we         = 1'b0;
        mem_wa         = clr_addr_reg;
        mem_wd         = '0;
        mem_ra         = s_index[AW-1:0];
        fin_valid      = 1'b0;
        fin            = '0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            fat12_cte_pkg::ST_IDLE: begin
                // read address goes out with the transfer
                if (s_axis_tvalid) begin
                    act_next   = s_action;
                    idx_next   = s_index;
                    val_next   = s_value;
                    state_next = fat12_cte_pkg::ST_EXEC;
                end
            end
            fat12_cte_pkg::ST_EXEC: begin
                case (act_reg)
                    fat12_cte_pkg::ACT_READ: begin
                        fin_valid = 1'b1;
                        if (idx_ok) begin
                            fin.entry_data = mem_rdata;
                        end else begin
                            fin.status = fat12_cte_pkg::STAT_RANGE;
                        end
                    end
                    fat12_cte_pkg::ACT_WRITE: begin
                        fin_valid = 1'b1;
                        if (idx_ok) begin
                            mem_we = 1'b1;
                            mem_wa = idx_reg[AW-1:0];
                            mem_wd = val_reg;
                        end else begin
                            fin.status = fat12_cte_pkg::STAT_RANGE;
                        end
                    end
                    fat12_cte_pkg::ACT_FIND, fat12_cte_pkg::ACT_COUNT: begin
                        scan_addr_next = '0;
                        pend_next      = 1'b0;
                        cnt_next       = '0;
                        state_next     = fat12_cte_pkg::ST_SCAN;
                    end
                    fat12_cte_pkg::ACT_CLEAR: begin
                        clr_addr_next = '0;
                        state_next    = fat12_cte_pkg::ST_CLEAR;
                    end
                    default: begin
                        fin_valid = 1'b1;
                    end
                endcase
            end
            fat12_cte_pkg::ST_SCAN: begin
                // one address issued per cycle, its data checked in the next
                mem_ra         = scan_addr_reg[AW-1:0];
                pend_next      = issue;
                pend_idx_next  = scan_addr_reg[AW-1:0];
                if (issue) begin
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
                if (act_reg == fat12_cte_pkg::ACT_FIND) begin
                    if (pend_reg && (mem_rdata == '0)) begin
                        fin_valid      = 1'b1;
                        fin.entry_data = EW'(pend_idx_reg);
                        pend_next      = 1'b0;
                    end else if (!issue && !pend_reg) begin
                        fin_valid  = 1'b1;
                        fin.status = fat12_cte_pkg::STAT_FULL;
                    end
                end else begin
                    if (pend_reg && (mem_rdata == '0)) begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (!issue && !pend_reg) begin
                        state_next = fat12_cte_pkg::ST_MUL;
                    end
                end
            end
            fat12_cte_pkg::ST_MUL: begin
                fin_valid      = 1'b1;
                fin.free_count = 13'(cnt_reg);
                fin.free_bytes = prod[31:0];
            end
            fat12_cte_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                if (clr_addr_reg == AW'(0)) begin
                    mem_wd = fat12_cte_pkg::MEDIA_MARK;
                end else if (clr_addr_reg == AW'(1)) begin
                    mem_wd = fat12_cte_pkg::CHAIN_END;
                end
                if (clr_addr_reg == LAST_IDX) begin
                    fin_valid = 1'b1;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            fat12_cte_pkg::ST_HOLD: begin
                fin_valid = 1'b1;
                fin       = hold_reg;
            end
            default: begin
                state_next = fat12_cte_pkg::ST_IDLE;
            end
        endcase

        // finished result goes to the output register, or waits in hold
        if (fin_valid) begin
            if (out_free) begin
                m_data_next  = fin;
                m_valid_next = 1'b1;
                state_next   = fat12_cte_pkg::ST_IDLE;
            end else begin
                hold_next  = fin;
                state_next = fat12_cte_pkg::ST_HOLD;
            end
        end
    end

    // table is never written while waiting for an item
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fat12_cte_pkg::ST_IDLE) |-> !mem_we)
        else $error("table write in idle");

    // every transfer starts execution in the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == fat12_cte_pkg::ST_EXEC))
        else $error("accepted item did not start");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result overwritten");

    // the hold state is only entered while the output is stalled
    a_hold_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fat12_cte_pkg::ST_HOLD) |-> m_valid_reg)
        else $error("hold without stalled output");

    // scan never runs past the scan limit
    a_scan_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fat12_cte_pkg::ST_SCAN) |-> (scan_addr_reg <= scan_lim))
        else $error("scan address past limit");

endmodule

### test/fat12_cluster_table_engine_core_tb.sv
// fat12_cluster_table_engine_core_tb: self-checking bench for the fat12 cluster table engine
// keeps a shadow table, predicts each result on the input transfer and compares the output stream
// depends on fat12_cte_pkg and the fat12_cluster_table_engine_core rtl
`timescale 1ns / 100ps

module fat12_cluster_table_engine_core_tb;

    localparam int          TBL_DEPTH   = 4096;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned PHASE_ITEMS = 102;
    localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;

    // action[2:0], index[14:3], value[26:15]
    typedef struct packed {
        logic [11:0] value;
        logic [11:0] index;
        logic [2:0]  action;
    } fat_cmd_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [19:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // action[2:0], index[14:3], value[26:15]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // status[1:0], entry_data[13:2],
                                 // free_count[26:14], free_bytes[58:27]

    fat12_cluster_table_engine_core #(.MAX_ENTRIES(TBL_DEPTH)) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow of the table and of the registers
    logic [11:0] shadow_fat [TBL_DEPTH];
    logic [12:0] shadow_entry_count;
    logic [19:0] shadow_cluster_bytes;

    fat_cmd_t                cmd_backlog [$];
    fat12_cte_pkg::result_t  pending_results [$];

    int unsigned cmds_queued;
    int unsigned cmds_taken;
    int unsigned results_seen;
    int unsigned fail_cnt;
    int unsigned cyc_cnt;
    int unsigned act_seen [8];
    int unsigned range_seen;
    int unsigned full_seen;
    int unsigned calm_left [2];
    int unsigned src_hold;
    int unsigned sink_hold;
    bit          s_fire;

    int unsigned ph_entries [11] = '{16, 2, 3, 4096, 5, 40, 4095, 8, 100, 1000, 0};
    int unsigned ph_bytes   [11] = '{1, 524288, 512, 4096, 7, 2048, 524288, 1, 300000,
                                     65536, 0};

    always #4 aclk = ~aclk;

    // applies one command to the shadow table and returns what the block must answer
    function automatic fat12_cte_pkg::result_t fat_execute(input fat_cmd_t c);
        fat12_cte_pkg::result_t r;
        int unsigned lim;
        int unsigned n;
        bit          found;
        r = '0;
        lim = (shadow_entry_count > TBL_DEPTH) ? TBL_DEPTH : shadow_entry_count;
        n = 0;
        found = 0;
        case (c.action)
            fat12_cte_pkg::ACT_READ: begin
                if ({1'b0, c.index} < shadow_entry_count) r.entry_data = shadow_fat[c.index];
                else r.status = fat12_cte_pkg::STAT_RANGE;
            end
            fat12_cte_pkg::ACT_WRITE: begin
                if ({1'b0, c.index} < shadow_entry_count) shadow_fat[c.index] = c.value;
                else r.status = fat12_cte_pkg::STAT_RANGE;
            end
            fat12_cte_pkg::ACT_FIND: begin
                r.status = fat12_cte_pkg::STAT_FULL;
                for (int i = 0; i < lim; i++) begin
                    if (!found && shadow_fat[i] == '0) begin
                        found = 1;
                        r.status = fat12_cte_pkg::STAT_OK;
                        r.entry_data = 12'(i);
                    end
                end
            end
            fat12_cte_pkg::ACT_COUNT: begin
                for (int i = 0; i < lim; i++)
                    if (shadow_fat[i] == '0) n++;
                r.free_count = 13'(n);
                r.free_bytes = 32'(longint'(n) * longint'(shadow_cluster_bytes));
            end
            fat12_cte_pkg::ACT_CLEAR: begin
                for (int i = 0; i < TBL_DEPTH; i++) shadow_fat[i] = '0;
                shadow_fat[0] = fat12_cte_pkg::MEDIA_MARK;
                shadow_fat[1] = fat12_cte_pkg::CHAIN_END;
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly back to back, sometimes short or long gaps, sometimes a calm stretch
    function automatic int unsigned pick_gap(input int side);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_left[side] != 0) begin
            calm_left[side]--;
            return 0;
        end
        if (r < 2) begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_cmd(input logic [2:0] act, input logic [11:0] idx,
                                      input logic [11:0] val);
        fat_cmd_t c;
        c.action = act;
        c.index  = idx;
        c.value  = val;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endfunction

    function automatic logic [11:0] pick_index(input int unsigned ec);
        if ($urandom_range(0, 99) < 80) return 12'($urandom_range(0, ec - 1));
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return '0;
        if (r < 35) return fat12_cte_pkg::CHAIN_END;
        if (r < 38) return fat12_cte_pkg::MEDIA_MARK;
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic queue_random(input int unsigned ec, input int unsigned n,
                                input int unsigned scan_pct);
        int unsigned made;
        int unsigned r;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 6 && ec <= 64) begin
                // allocate a whole chain over the table, then look for space
                for (int unsigned k = 0; k < ec; k++)
                    queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'(k), 12'($urandom_range(1, 4095)));
                if ($urandom_range(0, 1))
                    queue_cmd(fat12_cte_pkg::ACT_WRITE, pick_index(ec), '0);
                queue_cmd(fat12_cte_pkg::ACT_FIND, 12'($urandom), 12'($urandom));
                queue_cmd(fat12_cte_pkg::ACT_COUNT, 12'($urandom), 12'($urandom));
                made += ec + 2;
            end else if (r < 6 + scan_pct) begin
                queue_cmd($urandom_range(0, 1) ? fat12_cte_pkg::ACT_FIND
                                               : fat12_cte_pkg::ACT_COUNT,
                          12'($urandom), 12'($urandom));
                made++;
            end else if (r < 7 + scan_pct) begin
                queue_cmd(fat12_cte_pkg::ACT_CLEAR, 12'($urandom), 12'($urandom));
                made++;
            end else if (r < 10 + scan_pct) begin
                queue_cmd(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), 12'($urandom),
                          12'($urandom));
                made++;
            end else if (r < 65) begin
                queue_cmd(fat12_cte_pkg::ACT_WRITE, pick_index(ec), pick_value());
                made++;
            end else begin
                queue_cmd(fat12_cte_pkg::ACT_READ, pick_index(ec), 12'($urandom));
                made++;
            end
        end
    endtask

    // registers change only with the engine idle
    task automatic cfg_write(input logic [0:0] idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == fat12_cte_pkg::REG_ENTRY_COUNT) shadow_entry_count = val[12:0];
        else shadow_cluster_bytes = val;
    endtask

    task automatic drain();
        while (cmds_taken != cmds_queued || pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_fire)) begin
            if (src_hold != 0) begin
                src_hold--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, cmd_backlog.pop_front()};
                src_hold = pick_gap(0);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold != 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready <= 1'b1;
            sink_hold = pick_gap(1);
        end
    end

    // monitor: compare results, then predict from the input transfer
    always @(posedge aclk) begin
        fat12_cte_pkg::result_t got;
        fat12_cte_pkg::result_t want;
        fat_cmd_t               c;
        s_fire = aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = fat12_cte_pkg::result_t'(m_axis_tdata[58:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual 0x%0h", $time, m_axis_tdata);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("entry_data", 32'(want.entry_data), 32'(got.entry_data));
                check_field("free_count", 32'(want.free_count), 32'(got.free_count));
                check_field("free_bytes", want.free_bytes, got.free_bytes);
            end
        end
        if (s_fire) begin
            c = fat_cmd_t'(s_axis_tdata[26:0]);
            want = fat_execute(c);
            pending_results.push_back(want);
            cmds_taken++;
            act_seen[c.action]++;
            if (want.status == fat12_cte_pkg::STAT_RANGE) range_seen++;
            if (want.status == fat12_cte_pkg::STAT_FULL) full_seen++;
        end
    end

    always @(posedge aclk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        shadow_entry_count = fat12_cte_pkg::ENTRY_COUNT_RST;
        shadow_cluster_bytes = fat12_cte_pkg::CLUSTER_BYTES_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: format the table, then walk the markers and the top entry
        queue_cmd(fat12_cte_pkg::ACT_CLEAR, '0, '0);
        queue_cmd(fat12_cte_pkg::ACT_READ, 12'd0, '0);
        queue_cmd(fat12_cte_pkg::ACT_READ, 12'd1, '0);
        queue_cmd(fat12_cte_pkg::ACT_READ, 12'hFFF, '0);
        queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'hFFF, 12'hFFF);
        queue_cmd(fat12_cte_pkg::ACT_READ, 12'hFFF, 12'hFFF);
        queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'd2, 12'hAAA);
        queue_cmd(fat12_cte_pkg::ACT_FIND, 12'hFFF, 12'hFFF);
        queue_cmd(fat12_cte_pkg::ACT_COUNT, '0, '0);
        queue_cmd(ACT_UNUSED_LO, 12'hFFF, 12'hFFF);
        queue_cmd(3'(ACT_UNUSED_LO + 1), 12'h555, 12'hAAA);
        queue_cmd(ACT_UNUSED_HI, '0, '0);
        drain();

        // smallest table: out of range on both sides, full table, then one freed
        cfg_write(fat12_cte_pkg::REG_ENTRY_COUNT, 20'd2);
        cfg_write(fat12_cte_pkg::REG_CLUSTER_BYTES, 20'd524288);
        queue_cmd(fat12_cte_pkg::ACT_READ, 12'd2, '0);
        queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'hFFF, 12'h555);
        queue_cmd(fat12_cte_pkg::ACT_READ, 12'd1, '0);
        queue_cmd(fat12_cte_pkg::ACT_FIND, '0, '0);
        queue_cmd(fat12_cte_pkg::ACT_COUNT, '0, '0);
        queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'd1, '0);
        queue_cmd(fat12_cte_pkg::ACT_FIND, '0, '0);
        queue_cmd(fat12_cte_pkg::ACT_COUNT, '0, '0);
        drain();

        // whole table free at the largest cluster: the biggest byte count
        cfg_write(fat12_cte_pkg::REG_ENTRY_COUNT, 20'd4096);
        queue_cmd(fat12_cte_pkg::ACT_CLEAR, 12'h555, 12'hAAA);
        queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'd0, '0);
        queue_cmd(fat12_cte_pkg::ACT_WRITE, 12'd1, '0);
        queue_cmd(fat12_cte_pkg::ACT_COUNT, '0, '0);
        queue_cmd(fat12_cte_pkg::ACT_FIND, '0, '0);
        drain();

        for (int p = 0; p < 11; p++) begin
            if (ph_entries[p] == 0) ph_entries[p] = $urandom_range(2, 64);
            if (ph_bytes[p] == 0) ph_bytes[p] = $urandom_range(1, 524288);
            cfg_write(fat12_cte_pkg::REG_ENTRY_COUNT, 20'(ph_entries[p]));
            cfg_write(fat12_cte_pkg::REG_CLUSTER_BYTES, 20'(ph_bytes[p]));
            queue_random(ph_entries[p], PHASE_ITEMS, (ph_entries[p] > 256) ? 4 : 20);
            drain();
        end

        $display("covered %0d transfers in, %0d results out over 14 register settings",
                 cmds_taken, results_seen);
        $display("reads %0d writes %0d finds %0d counts %0d clears %0d, out of range %0d, full %0d",
                 act_seen[fat12_cte_pkg::ACT_READ], act_seen[fat12_cte_pkg::ACT_WRITE],
                 act_seen[fat12_cte_pkg::ACT_FIND], act_seen[fat12_cte_pkg::ACT_COUNT],
                 act_seen[fat12_cte_pkg::ACT_CLEAR], range_seen, full_seen);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
